@@ design/iep_pkg.sv @@
// ----------------------------------------------------------------------------
// iep_pkg
// shared types and defaults for the interrupt enable / pending register unit
// ----------------------------------------------------------------------------
package iep_pkg;

  // default geometry
  localparam int unsigned NumLinesDefault     = 60;
  localparam int unsigned PriorityBitsDefault = 4;

  // access codes carried by a request
  typedef enum logic [2:0] {
    ACT_ENABLE        = 3'd0,
    ACT_DISABLE       = 3'd1,
    ACT_SET_PENDING   = 3'd2,
    ACT_CLEAR_PENDING = 3'd3,
    ACT_READ_ENABLE   = 3'd4,
    ACT_READ_PENDING  = 3'd5,
    ACT_SET_PRIORITY  = 3'd6
  } action_e;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } ctl_state_e;

endpackage

@@ design/iep_ram.sv @@
// ----------------------------------------------------------------------------
// iep_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module iep_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/interrupt_enable_pending_registers_unit.sv @@
// ----------------------------------------------------------------------------
// interrupt_enable_pending_registers_unit
// enable, pending and priority register file of an interrupt controller
// ----------------------------------------------------------------------------
// Each request names an action and a line number and returns one response with
// a status, a read-back bit and the line's priority after the access. All per
// line state (enable bit, pending bit, priority) lives in one ram word per line;
// a request is read from the ram in the cycle it is accepted and the modified
// word is written back from ST_UPDATE once the output register is free or
// draining, so no new request is taken until the write-back is done. A bank
// of per-line valid flops, cleared by reset, makes a never-written line read
// as all zero, so no clearing pass is needed and the unit is usable straight
// out of reset. Line numbers at or above NumLines are answered with status 1
// and zero fields and leave the state untouched. A finished response waits
// in an output register, and the next request is still accepted while it
// waits. sub_priority_bits is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the unit is idle, the unit does not enforce
// it; values above PriorityBits act as PriorityBits.
module interrupt_enable_pending_registers_unit
  import iep_pkg::*;
#(
  parameter int unsigned NumLines     = NumLinesDefault,
  parameter int unsigned PriorityBits = PriorityBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  // request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic [7:0] irq_number_i,
  input  logic [3:0] group_priority_i,
  input  logic [3:0] sub_priority_i,
  // response channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       status_o,
  output logic       bit_value_o,
  output logic [3:0] priority_value_o
);

  localparam int unsigned AddrW  = (NumLines > 1) ? $clog2(NumLines) : 1;
  localparam int unsigned EntryW = PriorityBits + 2;
  localparam int unsigned ExtW   = (PriorityBits > 4) ? PriorityBits : 4;
  localparam logic [3:0]  PrioW4 = 4'(PriorityBits);
  localparam logic [7:0]  LinesLimit = 8'(NumLines);

  // ram word layout: {priority, pending, enable}
  localparam int unsigned EnPos = 0;
  localparam int unsigned PdPos = 1;

  // build a priority from group and sub parts under the given sub width
  function automatic logic [PriorityBits-1:0] encode_prio(
    input logic [3:0] grp,
    input logic [3:0] sub,
    input logic [3:0] sbits
  );
    logic [PriorityBits-1:0] pri;
    int unsigned             j;
    pri = '0;
    for (int unsigned i = 0; i < PriorityBits; i++) begin
      if (i < int'(sbits)) begin
        if (i < 4) begin
          pri[i] = sub[i[1:0]];
        end
      end else begin
        j = i - int'(sbits);
        if (j < 4) begin
          pri[i] = grp[j[1:0]];
        end
      end
    end
    return pri;
  endfunction

  // configuration register
  logic [2:0] sub_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_bits_q <= '0;
    end else if (cfg_we_i) begin
      sub_bits_q <= cfg_wdata_i;
    end
  end

  // saturated sub priority width
  logic [3:0] sub_sat;
  assign sub_sat = ({1'b0, sub_bits_q} > PrioW4) ? PrioW4 : {1'b0, sub_bits_q};

  // sequencer
  ctl_state_e state_q, state_d;
  logic       accept;
  logic       done;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_UPDATE: in_ready_o = 1'b0;
      default:   in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  logic [2:0]       act_q;
  logic [AddrW-1:0] addr_q;
  logic             in_range_q;
  logic [3:0]       grp_q;
  logic [3:0]       sub_q;
  logic             line_valid_q;
  logic [NumLines-1:0] valid_q;
  logic [AddrW-1:0] rd_addr;
  logic             rd_in_range;

  assign rd_addr     = irq_number_i[AddrW-1:0];
  assign rd_in_range = irq_number_i < LinesLimit;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q        <= action_i;
      addr_q       <= rd_addr;
      in_range_q   <= rd_in_range;
      grp_q        <= group_priority_i;
      sub_q        <= sub_priority_i;
      line_valid_q <= rd_in_range ? valid_q[rd_addr] : 1'b0;
    end
  end

  // state ram
  logic              ram_we;
  logic [EntryW-1:0] ram_rdata;
  logic [EntryW-1:0] cur_entry;
  logic [EntryW-1:0] new_entry;
  logic              bit_d;

  iep_ram #(
    .Width (EntryW),
    .Depth (NumLines)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (new_entry),
    .re_i    (accept && rd_in_range),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // a never-written line reads as reset value
  assign cur_entry = line_valid_q ? ram_rdata : '0;

  // modify step
  always_comb begin
    new_entry = cur_entry;
    bit_d     = 1'b0;
    case (act_q)
      ACT_ENABLE:        new_entry[EnPos] = 1'b1;
      ACT_DISABLE:       new_entry[EnPos] = 1'b0;
      ACT_SET_PENDING:   new_entry[PdPos] = 1'b1;
      ACT_CLEAR_PENDING: new_entry[PdPos] = 1'b0;
      ACT_READ_ENABLE:   bit_d = cur_entry[EnPos];
      ACT_READ_PENDING:  bit_d = cur_entry[PdPos];
      ACT_SET_PRIORITY: begin
        new_entry[EntryW-1:2] = encode_prio(grp_q, sub_q, sub_sat);
      end
      default: ;  // unused code leaves the line as is
    endcase
  end

  // output register must be free or draining to finish the update
  logic out_valid_q;
  assign done   = (state_q == ST_UPDATE) && (!out_valid_q || out_ready_i);
  assign ram_we = done && in_range_q;

  // per-line written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[addr_q] <= 1'b1;
    end
  end

  // response register
  logic [ExtW-1:0] prio_ext;
  logic            status_q;
  logic            bit_q;
  logic [3:0]      prio_q;

  assign prio_ext = ExtW'(new_entry[EntryW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q <= !in_range_q;
      bit_q    <= in_range_q ? bit_d : 1'b0;
      prio_q   <= in_range_q ? prio_ext[3:0] : 4'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign bit_value_o      = bit_q;
  assign priority_value_o = prio_q;

endmodule

@@ tb/tb_interrupt_enable_pending_registers_unit.sv @@
// ----------------------------------------------------------------------------
// tb_interrupt_enable_pending_registers_unit
// self-checking bench for the interrupt enable / pending / priority registers
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver; a clocked monitor takes
// the responses. Each accepted request is run through a local model of the
// enable, pending and priority state, and the predicted response is checked
// field by field against the response that comes out. A short directed list
// goes first, then random traffic under a series of sub-priority widths, with
// random gaps on both channels and two long response hold-offs.
module tb_interrupt_enable_pending_registers_unit;
  import iep_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumLines     = NumLinesDefault;
  localparam int unsigned PrioBits     = PriorityBitsDefault;
  localparam int unsigned RandPerPhase = 200;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned CycleLimit   = 600000;
  // action code with no defined behavior
  localparam logic [2:0]  ActReserved  = 3'd7;

  // one request as offered on the request channel
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] line;
    logic [3:0] grp;
    logic [3:0] sub;
  } access_t;

  // one response as seen on the response channel
  typedef struct packed {
    logic       status;
    logic       bit_value;
    logic [3:0] prio;
  } response_t;

  // clock, reset and every block input start at a known value
  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       cfg_we_i         = 1'b0;
  logic [2:0] cfg_wdata_i      = 3'd0;
  logic       in_valid_i       = 1'b0;
  logic [2:0] action_i         = 3'd0;
  logic [7:0] irq_number_i     = 8'd0;
  logic [3:0] group_priority_i = 4'd0;
  logic [3:0] sub_priority_i   = 4'd0;
  logic       out_ready_i      = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       status_o;
  logic       bit_value_o;
  logic [3:0] priority_value_o;

  // local copy of the register file and the grouping setting
  logic [NumLines-1:0] enable_mask;
  logic [NumLines-1:0] pending_mask;
  logic [PrioBits-1:0] prio_table [NumLines];
  logic [2:0]          sub_width_cfg;

  access_t     access_q [$];   // requests not yet offered
  response_t   resp_q [$];     // predicted responses, oldest first
  bit          quiet_mode   = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned accepted_cnt;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  int unsigned next_hold_at;
  int unsigned cycle_cnt    = 0;

  access_t     drv_acc;
  int unsigned drv_gap;
  response_t   mon_exp;
  int unsigned mon_gap;

  interrupt_enable_pending_registers_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .irq_number_i     (irq_number_i),
    .group_priority_i (group_priority_i),
    .sub_priority_i   (sub_priority_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .bit_value_o      (bit_value_o),
    .priority_value_o (priority_value_o)
  );

  always #10 clk_i = ~clk_i;

  // model state after reset
  initial begin
    enable_mask   = '0;
    pending_mask  = '0;
    sub_width_cfg = 3'd0;
    foreach (prio_table[i]) prio_table[i] = '0;
  end

  // apply one request to the local register file and return its response
  function automatic response_t predict_access(input access_t acc);
    response_t   resp;
    int unsigned sbits;
    int unsigned gbits;
    int unsigned packed_prio;
    resp = '0;
    // refused line: nothing changes, all fields but status are zero
    if (acc.line >= NumLines) begin
      resp.status = 1'b1;
      return resp;
    end
    case (acc.action)
      ACT_ENABLE:        enable_mask[acc.line]  = 1'b1;
      ACT_DISABLE:       enable_mask[acc.line]  = 1'b0;
      ACT_SET_PENDING:   pending_mask[acc.line] = 1'b1;
      ACT_CLEAR_PENDING: pending_mask[acc.line] = 1'b0;
      ACT_READ_ENABLE:   resp.bit_value = enable_mask[acc.line];
      ACT_READ_PENDING:  resp.bit_value = pending_mask[acc.line];
      ACT_SET_PRIORITY: begin
        // sub part in the low bits, group part above, each cut to its field;
        // a width beyond the priority size leaves no group bits
        sbits = (sub_width_cfg > PrioBits) ? PrioBits : sub_width_cfg;
        gbits = PrioBits - sbits;
        packed_prio = ((acc.grp & ((1 << gbits) - 1)) << sbits)
                    | (acc.sub & ((1 << sbits) - 1));
        prio_table[acc.line] = PrioBits'(packed_prio);
      end
      default: ;  // reserved code: range check only
    endcase
    resp.prio = 4'(prio_table[acc.line]);
    return resp;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // random request: mostly valid lines with a few hot ones so reads hit
  // lines that were just written; the rest out of range or reserved
  function automatic access_t random_access();
    access_t     acc;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    acc.action = (roll < 95) ? 3'($urandom_range(0, 6)) : ActReserved;
    roll = $urandom_range(0, 99);
    if (roll < 65)      acc.line = 8'($urandom_range(0, NumLines - 1));
    else if (roll < 82) acc.line = 8'($urandom_range(0, 3)) | ((roll & 1) ? 8'd56 : 8'd0);
    else                acc.line = 8'($urandom_range(NumLines, 255));
    acc.grp = 4'($urandom_range(0, 15));
    acc.sub = 4'($urandom_range(0, 15));
    return acc;
  endfunction

  task automatic queue_access(input logic [2:0] action, input logic [7:0] line,
                              input logic [3:0] grp, input logic [3:0] sub);
    access_q.push_back('{action, line, grp, sub});
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // block is idle once every request went out and every response came back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (access_q.size() != 0 || in_valid_i || resp_q.size() != 0);
  endtask

  // grouping register write, only while the block is idle
  task automatic set_sub_width(input logic [2:0] width);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    sub_width_cfg = width;
  endtask

  // request driver: predicts on accept, then idles or offers the next request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      src_gap      <= 0;
      accepted_cnt <= 0;
    end else begin
      drv_gap = 0;
      if (in_valid_i && in_ready_o) begin
        drv_acc = {action_i, irq_number_i, group_priority_i, sub_priority_i};
        resp_q.push_back(predict_access(drv_acc));
        accepted_cnt <= accepted_cnt + 1;
        drv_gap = pick_gap();
      end
      if (in_valid_i && !in_ready_o) begin
        // request still waiting: hold valid and payload
      end else if (src_gap != 0) begin
        in_valid_i <= 1'b0;
        src_gap    <= src_gap - 1;
      end else if (drv_gap != 0) begin
        in_valid_i <= 1'b0;
        src_gap    <= drv_gap - 1;
      end else if (access_q.size() != 0) begin
        drv_acc           = access_q.pop_front();
        in_valid_i       <= 1'b1;
        action_i         <= drv_acc.action;
        irq_number_i     <= drv_acc.line;
        group_priority_i <= drv_acc.grp;
        sub_priority_i   <= drv_acc.sub;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long response hold-off, twice during the run, so the block backs up
  // and has to drop in_ready_o while requests keep coming
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      next_hold_at <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (accepted_cnt >= next_hold_at) begin
      hold_left    <= HoldCycles;
      next_hold_at <= next_hold_at + 700;
    end
  end

  // response monitor: check against the oldest prediction, then pace ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_gap    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (resp_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          mon_exp = resp_q.pop_front();
          if (status_o !== mon_exp.status)
            report_mismatch($sformatf("status %b, predicted %b", status_o, mon_exp.status));
          if (bit_value_o !== mon_exp.bit_value)
            report_mismatch($sformatf("bit_value %b, predicted %b",
                                      bit_value_o, mon_exp.bit_value));
          if (priority_value_o !== mon_exp.prio)
            report_mismatch($sformatf("priority_value %0d, predicted %0d",
                                      priority_value_o, mon_exp.prio));
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (sink_gap != 0) begin
        out_ready_i <= 1'b0;
        sink_gap    <= sink_gap - 1;
      end else if (out_valid_o && out_ready_i) begin
        mon_gap      = pick_gap();
        out_ready_i <= (mon_gap == 0);
        sink_gap    <= (mon_gap == 0) ? 0 : mon_gap - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_interrupt_enable_pending_registers_unit failed");
      $finish;
    end
  end

  initial begin
    logic [2:0] width_plan [7] = '{3'd2, 3'd4, 3'd1, 3'd7, 3'd3, 3'd0, 3'd5};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed list, plain priority (no sub bits)
    set_sub_width(3'd0);
    queue_access(ACT_READ_ENABLE,   8'd0,   4'd0,  4'd0);   // reads zero after reset
    queue_access(ACT_ENABLE,        8'd0,   4'd0,  4'd0);
    queue_access(ACT_READ_ENABLE,   8'd0,   4'd0,  4'd0);
    queue_access(ACT_DISABLE,       8'd0,   4'd0,  4'd0);
    queue_access(ACT_READ_ENABLE,   8'd0,   4'd0,  4'd0);
    queue_access(ACT_SET_PENDING,   8'd59,  4'd0,  4'd0);   // last valid line
    queue_access(ACT_READ_PENDING,  8'd59,  4'd0,  4'd0);
    queue_access(ACT_CLEAR_PENDING, 8'd59,  4'd0,  4'd0);
    queue_access(ACT_READ_PENDING,  8'd59,  4'd0,  4'd0);
    queue_access(ACT_SET_PRIORITY,  8'd59,  4'd15, 4'd15);
    queue_access(ACT_SET_PRIORITY,  8'd0,   4'd0,  4'd0);
    queue_access(ActReserved,       8'd59,  4'd0,  4'd0);   // reserved code, in range
    queue_access(ACT_ENABLE,        8'd60,  4'd0,  4'd0);   // first refused line
    queue_access(ACT_SET_PRIORITY,  8'd255, 4'd15, 4'd15);  // refused priority write
    queue_access(ACT_READ_ENABLE,   8'd60,  4'd0,  4'd0);
    queue_access(ACT_SET_PENDING,   8'd128, 4'd0,  4'd0);
    queue_access(ActReserved,       8'd255, 4'd15, 4'd15);  // reserved code, refused
    queue_access(ACT_READ_PENDING,  8'd59,  4'd0,  4'd0);
    queue_access(ACT_CLEAR_PENDING, 8'd200, 4'd0,  4'd0);
    queue_access(ACT_SET_PRIORITY,  8'd1,   4'd10, 4'd5);
    queue_access(ACT_READ_PENDING,  8'd0,   4'd0,  4'd0);
    queue_access(ACT_SET_PENDING,   8'd0,   4'd0,  4'd0);
    queue_access(ACT_READ_PENDING,  8'd0,   4'd0,  4'd0);
    queue_access(ACT_DISABLE,       8'd255, 4'd0,  4'd0);
    wait_drained();

    // random traffic under each grouping, oversized width included;
    // one phase runs with no random gaps on either channel
    foreach (width_plan[i]) begin
      set_sub_width(width_plan[i]);
      quiet_mode = (i == 4);
      repeat (RandPerPhase) access_q.push_back(random_access());
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("tb_interrupt_enable_pending_registers_unit passed");
    else
      $display("tb_interrupt_enable_pending_registers_unit failed");
    $finish;
  end

endmodule
